// ===== rtl/ttr_pkg.sv =====
// Shared types, constants and helpers for the triggered transient recorder.
// Depends on nothing; used by ttr_store and triggered_transient_recorder.
package ttr_pkg;

  localparam int unsigned StoreDepth = 1024;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned CountW     = $clog2(StoreDepth + 1);
  localparam int unsigned DataW      = 32;
  localparam int unsigned CfgIdxW    = 3;

  localparam logic [CountW-1:0] MaxLength = CountW'(StoreDepth);

  typedef enum logic [3:0] {
    OpProc    = 4'd0,
    OpPoll    = 4'd1,
    OpSample  = 4'd2,
    OpArm     = 4'd3,
    OpDisarm  = 4'd4,
    OpStart   = 4'd5,
    OpStop    = 4'd6,
    OpReset   = 4'd7,
    OpRead    = 4'd8
  } op_e;

  localparam logic [2:0] ModeLevelHigh = 3'd0;
  localparam logic [2:0] ModeLevelLow  = 3'd1;
  localparam logic [2:0] ModeRising    = 3'd2;
  localparam logic [2:0] ModeFalling   = 3'd3;
  localparam logic [2:0] ModeManual    = 3'd4;

  localparam logic [1:0] SizeByte = 2'd0;
  localparam logic [1:0] SizeHalf = 2'd1;
  localparam logic [1:0] SizeWord = 2'd2;
  localparam logic [1:0] SizeNone = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgTrigMode   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTrigThresh = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTrigSize   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSampleSize = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRecLength  = 3'd4;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  function automatic logic [DataW-1:0] sext_sized(logic [DataW-1:0] v, logic [1:0] size);
    logic [DataW-1:0] r;
    case (size)
      SizeByte: r = {{24{v[7]}}, v[7:0]};
      SizeHalf: r = {{16{v[15]}}, v[15:0]};
      SizeWord: r = v;
      default:  r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [DataW-1:0] trunc_sized(logic [DataW-1:0] v, logic [1:0] size);
    logic [DataW-1:0] r;
    case (size)
      SizeByte: r = {24'd0, v[7:0]};
      SizeHalf: r = {16'd0, v[15:0]};
      default:  r = v;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/triggered_transient_recorder.sv =====
// Top level of the triggered transient recorder: trigger, capture control,
// result pipeline and configuration registers. Depends on ttr_pkg and ttr_store.
//
//  Channel   Direction  Transfer              Contents
//  s_axis    in         tvalid && tready      one command transaction
//  m_axis    out        tvalid && tready      one result transaction per command
//  cfg       in         cfg_we_i              register write, no wait
//
// One command is taken per cycle while the output does not stall; its result
// is registered in the store-read stage, with the registered read port of the
// sample store, and then in the output register. The store needs no clearing
// pass after reset. A stalled output holds the result register and then the
// store-read stage before s_axis_tready falls.
module triggered_transient_recorder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [3:0] opcode, [35:4] trigger_value, [67:36] sample_value,
  // [77:68] read_index, [79:78] zero
  input  logic [79:0]                   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [1:0] status, [12:2] sample_count, [13] trigger_fired,
  // [45:14] read_data, [47:46] zero
  output logic [47:0]                   m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [ttr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ttr_pkg::DataW-1:0]     cfg_data_i
);

  typedef enum logic [1:0] {
    StIdle      = 2'd0,
    StArmed     = 2'd1,
    StRecording = 2'd2,
    StComplete  = 2'd3
  } status_e;

  localparam int unsigned CW = ttr_pkg::CountW;
  localparam int unsigned DW = ttr_pkg::DataW;
  localparam int unsigned AW = ttr_pkg::AddrW;

  logic [2:0]    trig_mode_q;
  logic [DW-1:0] trig_thresh_q;
  logic [1:0]    trig_size_q;
  logic [1:0]    sample_size_q;
  logic [CW-1:0] rec_length_q;

  status_e       st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] prev_q, prev_d;
  logic          pv_q, pv_d;

  logic          s1_valid_q;
  logic [1:0]    s1_status_q;
  logic [CW-1:0] s1_count_q;
  logic          s1_fired_q;
  logic          s1_rd_ok_q;

  logic          out_valid_q;
  logic [1:0]    out_status_q;
  logic [CW-1:0] out_count_q;
  logic          out_fired_q;
  logic [DW-1:0] out_rdata_q;

  logic          accept;
  logic          s1_adv;
  logic          fired;
  logic          rd_ok;
  logic [DW-1:0] mem_rdata;
  ttr_pkg::mem_req_t mem_req;

  ttr_pkg::op_e  op;
  logic [DW-1:0] trig_val;
  logic [DW-1:0] samp_val;
  logic [AW-1:0] rd_idx;

  logic [DW-1:0] cur;
  logic          cur_lt, cur_le, prev_lt, th_lt_prev;
  logic [CW-1:0] eff_len;
  logic [CW-1:0] cnt_inc;

  assign op       = ttr_pkg::op_e'(s_axis_tdata[3:0]);
  assign trig_val = s_axis_tdata[35:4];
  assign samp_val = s_axis_tdata[67:36];
  assign rd_idx   = s_axis_tdata[77:68];

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign cur        = ttr_pkg::sext_sized(trig_val, trig_size_q);
  assign cur_lt     = $signed(cur) < $signed(trig_thresh_q);
  assign cur_le     = $signed(cur) <= $signed(trig_thresh_q);
  assign prev_lt    = $signed(prev_q) < $signed(trig_thresh_q);
  assign th_lt_prev = $signed(trig_thresh_q) < $signed(prev_q);
  assign eff_len    = (rec_length_q > ttr_pkg::MaxLength) ? ttr_pkg::MaxLength : rec_length_q;
  assign cnt_inc    = cnt_q + CW'(1);
  assign rd_ok      = {1'b0, rd_idx} < cnt_q;

  always_comb begin
    logic do_poll;
    logic do_sample;
    st_d         = st_q;
    cnt_d        = cnt_q;
    prev_d       = prev_q;
    pv_d         = pv_q;
    fired        = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = cnt_q[AW-1:0];
    mem_req.wdata = ttr_pkg::trunc_sized(samp_val, sample_size_q);
    mem_req.re    = 1'b0;
    mem_req.raddr = rd_idx;
    do_poll   = 1'b0;
    do_sample = 1'b0;

    if (accept) begin
      unique case (op)
        ttr_pkg::OpProc: begin
          do_poll   = (st_q == StArmed);
          do_sample = (st_q == StRecording);
        end
        ttr_pkg::OpPoll:   do_poll   = (st_q == StArmed);
        ttr_pkg::OpSample: do_sample = (st_q == StRecording);
        ttr_pkg::OpArm: begin
          st_d  = StArmed;
          cnt_d = '0;
          pv_d  = 1'b0;
        end
        ttr_pkg::OpDisarm: begin
          if (st_q == StArmed) begin
            st_d = StIdle;
          end
        end
        ttr_pkg::OpStart: begin
          st_d  = StRecording;
          cnt_d = '0;
        end
        ttr_pkg::OpStop: begin
          if (st_q == StRecording) begin
            st_d = StComplete;
          end
        end
        ttr_pkg::OpReset: begin
          st_d  = StIdle;
          cnt_d = '0;
          pv_d  = 1'b0;
        end
        ttr_pkg::OpRead: mem_req.re = 1'b1;
        default: ;
      endcase
    end

    if (do_poll) begin
      case (trig_mode_q)
        ttr_pkg::ModeLevelHigh: fired = !cur_lt;
        ttr_pkg::ModeLevelLow:  fired = cur_le;
        ttr_pkg::ModeRising:    fired = pv_q && prev_lt && !cur_lt;
        ttr_pkg::ModeFalling:   fired = pv_q && th_lt_prev && cur_le;
        default:                fired = 1'b0;
      endcase
      prev_d = cur;
      pv_d   = 1'b1;
      if (fired) begin
        cnt_d = '0;
        st_d  = StRecording;
      end
    end

    if (do_sample) begin
      if (cnt_q >= eff_len) begin
        st_d = StComplete;
      end else begin
        mem_req.we = (sample_size_q != ttr_pkg::SizeNone);
        cnt_d      = cnt_inc;
        if (cnt_inc >= eff_len) begin
          st_d = StComplete;
        end
      end
    end

    if (cfg_we_i && (cfg_idx_i == ttr_pkg::CfgTrigMode || cfg_idx_i == ttr_pkg::CfgTrigThresh)) begin
      pv_d = 1'b0;
    end
  end

  ttr_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_mode_q   <= ttr_pkg::ModeManual;
      trig_thresh_q <= '0;
      trig_size_q   <= ttr_pkg::SizeWord;
      sample_size_q <= ttr_pkg::SizeWord;
      rec_length_q  <= ttr_pkg::MaxLength;
      st_q          <= StIdle;
      cnt_q         <= '0;
      prev_q        <= '0;
      pv_q          <= 1'b0;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ttr_pkg::CfgTrigMode:   trig_mode_q   <= cfg_data_i[2:0];
          ttr_pkg::CfgTrigThresh: trig_thresh_q <= cfg_data_i;
          ttr_pkg::CfgTrigSize:   trig_size_q   <= cfg_data_i[1:0];
          ttr_pkg::CfgSampleSize: sample_size_q <= cfg_data_i[1:0];
          ttr_pkg::CfgRecLength:  rec_length_q  <= cfg_data_i[CW-1:0];
          default: ;
        endcase
      end
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      prev_q <= prev_d;
      pv_q   <= pv_d;
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_status_q <= st_d;
      s1_count_q  <= cnt_d;
      s1_fired_q  <= fired;
      s1_rd_ok_q  <= mem_req.re && rd_ok;
    end
    if (s1_adv) begin
      out_status_q <= s1_status_q;
      out_count_q  <= s1_count_q;
      out_fired_q  <= s1_fired_q;
      out_rdata_q  <= s1_rd_ok_q ? ttr_pkg::sext_sized(mem_rdata, sample_size_q) : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_rdata_q, out_fired_q, out_count_q, out_status_q};

endmodule

// ===== rtl/ttr_store.sv =====
// Sample store of the triggered transient recorder: one write port, one
// registered read port. Depends on ttr_pkg.
module ttr_store (
  input  logic                         clk_i,
  input  ttr_pkg::mem_req_t            req_i,
  output logic [ttr_pkg::DataW-1:0]    rdata_o
);

  logic [ttr_pkg::DataW-1:0] mem [ttr_pkg::StoreDepth];
  logic [ttr_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== test/triggered_transient_recorder_test.sv =====
// Self-checking testbench for triggered_transient_recorder: directed, per-mode, random and
// full-capture command streams with random stalls on both stream sides, checked against a
// local predictor. Depends on ttr_pkg and the triggered_transient_recorder RTL only.
module triggered_transient_recorder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] StIdle      = 2'd0;
  localparam logic [1:0] StArmed     = 2'd1;
  localparam logic [1:0] StRecording = 2'd2;
  localparam logic [1:0] StComplete  = 2'd3;

  localparam logic [3:0] OpFirstUnused = 4'd9;
  localparam logic [3:0] OpLastUnused  = 4'd15;

  localparam logic [4:0] AllRegs     = 5'b11111;
  localparam int         CycleLimit  = 400000;
  localparam int         RandomItems = 120;

  localparam int unsigned DW = ttr_pkg::DataW;
  localparam int unsigned CW = ttr_pkg::CountW;
  localparam int unsigned AW = ttr_pkg::AddrW;
  localparam int unsigned IW = ttr_pkg::CfgIdxW;

  typedef struct packed {
    logic [1:0]    pad;
    logic [DW-1:0] read_data;
    logic          fired;
    logic [CW-1:0] count;
    logic [1:0]    status;
  } rec_result_t;

  logic          clk_i;
  logic          rst_ni;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [79:0]   s_axis_tdata;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [47:0]   m_axis_tdata;
  logic          cfg_we_i;
  logic [IW-1:0] cfg_idx_i;
  logic [DW-1:0] cfg_data_i;

  // Predictor copy of the configuration and capture state.
  logic [2:0]                    cfg_mode;
  logic [DW-1:0]                 cfg_thresh;
  logic [1:0]                    cfg_tsize;
  logic [1:0]                    cfg_ssize;
  logic [CW-1:0]                 cfg_length;
  logic [1:0]                    rec_status;
  logic [CW-1:0]                 rec_count;
  logic [DW-1:0]                 last_trigger;
  logic                          last_valid;
  logic [DW-1:0]                 sample_mem [ttr_pkg::StoreDepth];
  logic [ttr_pkg::StoreDepth-1:0] mem_filled;

  rec_result_t expected_results[$];
  int          mismatches;
  int          cycles;
  int          items_sent;
  bit          quiet;

  triggered_transient_recorder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [DW-1:0] sign_widen(logic [DW-1:0] v, logic [1:0] size);
    case (size)
      ttr_pkg::SizeByte: return 32'($signed(v[7:0]));
      ttr_pkg::SizeHalf: return 32'($signed(v[15:0]));
      ttr_pkg::SizeWord: return v;
      default:           return '0;
    endcase
  endfunction

  function automatic void clear_capture();
    rec_status = StIdle;
    rec_count  = '0;
    last_valid = 1'b0;
    mem_filled = '0;
  endfunction

  function automatic logic trigger_poll(logic [DW-1:0] raw);
    logic signed [DW-1:0] cur;
    logic signed [DW-1:0] th;
    logic signed [DW-1:0] prev;
    logic                 hit;
    if (rec_status != StArmed) return 1'b0;
    cur  = sign_widen(raw, cfg_tsize);
    th   = cfg_thresh;
    prev = last_trigger;
    case (cfg_mode)
      ttr_pkg::ModeLevelHigh: hit = cur >= th;
      ttr_pkg::ModeLevelLow:  hit = cur <= th;
      ttr_pkg::ModeRising:    hit = last_valid && prev < th && cur >= th;
      ttr_pkg::ModeFalling:   hit = last_valid && prev > th && cur <= th;
      default:                hit = 1'b0;
    endcase
    last_trigger = cur;
    last_valid   = 1'b1;
    if (hit) begin
      rec_count  = '0;
      rec_status = StRecording;
      mem_filled = '0;
    end
    return hit;
  endfunction

  function automatic void sample_take(logic [DW-1:0] raw);
    logic [CW-1:0] limit;
    limit = (cfg_length > ttr_pkg::MaxLength) ? ttr_pkg::MaxLength : cfg_length;
    if (rec_status != StRecording) return;
    if (rec_count >= limit) begin
      rec_status = StComplete;
      return;
    end
    case (cfg_ssize)
      ttr_pkg::SizeByte: sample_mem[rec_count[AW-1:0]] = {24'd0, raw[7:0]};
      ttr_pkg::SizeHalf: sample_mem[rec_count[AW-1:0]] = {16'd0, raw[15:0]};
      ttr_pkg::SizeWord: sample_mem[rec_count[AW-1:0]] = raw;
      default: ;
    endcase
    if (cfg_ssize != ttr_pkg::SizeNone) mem_filled[rec_count[AW-1:0]] = 1'b1;
    rec_count = rec_count + 1'b1;
    if (rec_count >= limit) rec_status = StComplete;
  endfunction

  function automatic rec_result_t recorder_step(logic [3:0] opcode, logic [DW-1:0] tval,
                                                logic [DW-1:0] sval, logic [AW-1:0] ridx);
    rec_result_t r;
    r = '0;
    case (opcode)
      ttr_pkg::OpProc: begin
        if (rec_status == StArmed) r.fired = trigger_poll(tval);
        else if (rec_status == StRecording) sample_take(sval);
      end
      ttr_pkg::OpPoll:   r.fired = trigger_poll(tval);
      ttr_pkg::OpSample: sample_take(sval);
      ttr_pkg::OpArm: begin
        clear_capture();
        rec_status = StArmed;
      end
      ttr_pkg::OpDisarm: if (rec_status == StArmed) rec_status = StIdle;
      ttr_pkg::OpStart: begin
        rec_count  = '0;
        rec_status = StRecording;
        mem_filled = '0;
      end
      ttr_pkg::OpStop:  if (rec_status == StRecording) rec_status = StComplete;
      ttr_pkg::OpReset: clear_capture();
      ttr_pkg::OpRead: begin
        if ({1'b0, ridx} < rec_count) r.read_data = sign_widen(sample_mem[ridx], cfg_ssize);
      end
      default: ;
    endcase
    r.status = rec_status;
    r.count  = rec_count;
    return r;
  endfunction

  function automatic logic [DW-1:0] pick_threshold(logic [1:0] size);
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      default: return sign_widen($urandom, size);
    endcase
  endfunction

  function automatic logic [DW-1:0] near_trigger();
    logic [DW-1:0] v;
    int            d;
    d = int'($urandom_range(0, 4)) - 2;
    case ($urandom_range(0, 5))
      0:       v = $urandom;
      1:       v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: v = cfg_thresh + 32'(d);
    endcase
    case (cfg_tsize)
      ttr_pkg::SizeByte: v[31:8] = 24'($urandom);
      ttr_pkg::SizeHalf: v[31:16] = 16'($urandom);
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [AW-1:0] pick_index();
    if ($urandom_range(0, 3) == 0) return AW'($urandom);
    return AW'($urandom_range(0, int'(rec_count) + 1));
  endfunction

  function automatic logic [CW-1:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return ttr_pkg::MaxLength;
      3:       return CW'($urandom_range(0, 2047));
      default: return CW'($urandom_range(1, 10));
    endcase
  endfunction

  task automatic send_cmd(input logic [3:0] opcode, input logic [DW-1:0] tval,
                          input logic [DW-1:0] sval, input logic [AW-1:0] ridx);
    // Entries below the count that were never filled in this capture are not read.
    if (opcode == ttr_pkg::OpRead && {1'b0, ridx} < rec_count && !mem_filled[ridx]) begin
      if (rec_count < ttr_pkg::MaxLength)
        ridx = AW'(int'(rec_count) +
                   $urandom_range(0, ttr_pkg::StoreDepth - 1 - int'(rec_count)));
      else
        opcode = OpFirstUnused;
    end
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, ridx, sval, tval, opcode};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(recorder_step(opcode, tval, sval, ridx));
    items_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input logic [DW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [4:0] sel, input logic [2:0] mode,
                          input logic [DW-1:0] thresh, input logic [1:0] tsize,
                          input logic [1:0] ssize, input logic [CW-1:0] len);
    wait_drained();
    if (sel[ttr_pkg::CfgTrigMode]) begin
      write_reg(ttr_pkg::CfgTrigMode, 32'(mode));
      cfg_mode   = mode;
      last_valid = 1'b0;
    end
    if (sel[ttr_pkg::CfgTrigThresh]) begin
      write_reg(ttr_pkg::CfgTrigThresh, thresh);
      cfg_thresh = thresh;
      last_valid = 1'b0;
    end
    if (sel[ttr_pkg::CfgTrigSize]) begin
      write_reg(ttr_pkg::CfgTrigSize, 32'(tsize));
      cfg_tsize = tsize;
    end
    if (sel[ttr_pkg::CfgSampleSize]) begin
      write_reg(ttr_pkg::CfgSampleSize, 32'(ssize));
      cfg_ssize = ssize;
    end
    if (sel[ttr_pkg::CfgRecLength]) begin
      write_reg(ttr_pkg::CfgRecLength, 32'(len));
      cfg_length = len;
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_noise();
    send_cmd(4'($urandom), $urandom, $urandom, AW'($urandom));
  endtask

  task automatic run_capture(input int polls, input int samples, input int reads);
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) send_cmd(ttr_pkg::OpArm, $urandom, $urandom, AW'($urandom));
    else if (pick < 15) send_cmd(ttr_pkg::OpStart, $urandom, $urandom, AW'($urandom));
    for (int i = 0; i < polls && rec_status == StArmed; i++) begin
      if ($urandom_range(0, 11) == 0) send_noise();
      else send_cmd($urandom_range(0, 1) ? ttr_pkg::OpPoll : ttr_pkg::OpProc, near_trigger(),
                    $urandom, AW'($urandom));
    end
    for (int i = 0; i < samples && rec_status == StRecording; i++) begin
      pick = $urandom_range(0, 23);
      if (pick == 0) send_noise();
      else if (pick == 1) send_cmd(ttr_pkg::OpStop, $urandom, $urandom, AW'($urandom));
      else send_cmd(pick[0] ? ttr_pkg::OpSample : ttr_pkg::OpProc, $urandom, $urandom,
                    AW'($urandom));
    end
    for (int i = 0; i < reads; i++) send_cmd(ttr_pkg::OpRead, $urandom, $urandom, pick_index());
    case ($urandom_range(0, 5))
      0: send_cmd(ttr_pkg::OpDisarm, $urandom, $urandom, AW'($urandom));
      1: send_cmd(ttr_pkg::OpReset, $urandom, $urandom, AW'($urandom));
      2: send_cmd(ttr_pkg::OpStop, $urandom, $urandom, AW'($urandom));
      default: ;
    endcase
  endtask

  task automatic test_directed();
    send_cmd(ttr_pkg::OpProc, 32'h7FFF_FFFF, 32'h8000_0000, '0);
    send_cmd(ttr_pkg::OpPoll, 32'h8000_0000, '0, '0);
    send_cmd(ttr_pkg::OpSample, '0, 32'hFFFF_FFFF, '0);
    send_cmd(ttr_pkg::OpDisarm, '0, '0, '0);
    send_cmd(ttr_pkg::OpStop, '0, '0, '0);
    send_cmd(ttr_pkg::OpRead, '0, '0, '0);
    send_cmd(ttr_pkg::OpArm, '1, '1, '1);
    send_cmd(ttr_pkg::OpPoll, 32'h7FFF_FFFF, '0, '0);
    send_cmd(ttr_pkg::OpProc, 32'h8000_0000, '0, '0);
    send_cmd(ttr_pkg::OpDisarm, '0, '0, '0);
    send_cmd(ttr_pkg::OpStart, '0, '0, '0);
    send_cmd(ttr_pkg::OpSample, '0, 32'h8000_0000, '0);
    send_cmd(ttr_pkg::OpProc, '0, 32'h7FFF_FFFF, '0);
    send_cmd(ttr_pkg::OpSample, '0, 32'hFFFF_FFFF, '0);
    send_cmd(ttr_pkg::OpRead, '0, '0, '0);
    send_cmd(ttr_pkg::OpRead, '0, '0, 10'd2);
    send_cmd(ttr_pkg::OpRead, '0, '0, '1);
    send_cmd(ttr_pkg::OpStop, '0, '0, '0);
    send_cmd(ttr_pkg::OpStop, '0, '0, '0);
    send_cmd(ttr_pkg::OpSample, '0, 32'h1234_5678, '0);
    send_cmd(OpFirstUnused, '1, '1, '1);
    send_cmd(OpLastUnused, '1, '1, '1);
    send_cmd(ttr_pkg::OpReset, '0, '0, '0);
    send_cmd(ttr_pkg::OpArm, '0, '0, '0);
    send_cmd(ttr_pkg::OpStart, '0, '0, '0);
  endtask

  task automatic test_trigger_modes();
    logic [1:0] tsize;
    for (int m = 0; m < 8; m++) begin
      tsize = 2'(m);
      set_regs(AllRegs, 3'(m), pick_threshold(tsize), tsize, 2'($urandom_range(0, 3)),
               CW'($urandom_range(1, 6)));
      run_capture(10, 8, 3);
    end
  endtask

  task automatic test_random();
    int         target;
    logic [1:0] tsize;
    logic [2:0] mode;
    target = items_sent + RandomItems;
    while (items_sent < target) begin
      if ($urandom_range(0, 2) != 0) begin
        tsize = 2'($urandom_range(0, 3));
        mode  = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
        set_regs(5'($urandom_range(1, 31)), mode, pick_threshold(tsize), tsize,
                 2'($urandom_range(0, 3)), pick_length());
      end
      run_capture($urandom_range(1, 12), $urandom_range(1, 14), $urandom_range(1, 6));
    end
  endtask

  task automatic test_full_capture();
    set_regs(AllRegs, ttr_pkg::ModeLevelHigh, 32'h8000_0000, ttr_pkg::SizeWord,
             2'($urandom_range(0, 2)), '1);
    send_cmd(ttr_pkg::OpArm, '0, '0, '0);
    send_cmd(ttr_pkg::OpPoll, $urandom, '0, '0);
    while (rec_status == StRecording)
      send_cmd($urandom_range(0, 1) ? ttr_pkg::OpSample : ttr_pkg::OpProc, $urandom, $urandom,
               AW'($urandom));
    send_cmd(ttr_pkg::OpSample, '0, $urandom, '0);
    send_cmd(ttr_pkg::OpRead, '0, '0, '1);
    send_cmd(ttr_pkg::OpRead, '0, '0, '0);
    for (int i = 0; i < 40; i++) send_cmd(ttr_pkg::OpRead, $urandom, $urandom, AW'($urandom));
    set_regs(5'(1) << ttr_pkg::CfgSampleSize, cfg_mode, cfg_thresh, cfg_tsize,
             2'($urandom_range(0, 3)), cfg_length);
    for (int i = 0; i < 20; i++) send_cmd(ttr_pkg::OpRead, $urandom, $urandom, AW'($urandom));
    set_regs(5'(1) << ttr_pkg::CfgRecLength, cfg_mode, cfg_thresh, cfg_tsize, cfg_ssize, '0);
    send_cmd(ttr_pkg::OpStart, '0, '0, '0);
    send_cmd(ttr_pkg::OpSample, '0, $urandom, '0);
    send_cmd(ttr_pkg::OpRead, '0, '0, '0);
    set_regs(5'(1) << ttr_pkg::CfgRecLength, cfg_mode, cfg_thresh, cfg_tsize, cfg_ssize,
             11'd1);
    send_cmd(ttr_pkg::OpStart, '0, '0, '0);
    send_cmd(ttr_pkg::OpProc, '0, $urandom, '0);
    send_cmd(ttr_pkg::OpRead, '0, '0, '0);
    send_cmd(ttr_pkg::OpReset, '0, '0, '0);
  endtask

  task automatic check_field(input string name, input logic [DW-1:0] want,
                             input logic [DW-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("%s mismatch: expected %h, got %h", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    rec_result_t got;
    rec_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result transaction with none expected: %h", got);
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("sample_count", 32'(want.count), 32'(got.count));
        check_field("trigger_fired", 32'(want.fired), 32'(got.fired));
        check_field("read_data", want.read_data, got.read_data);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    cfg_mode      = ttr_pkg::ModeManual;
    cfg_thresh    = '0;
    cfg_tsize     = ttr_pkg::SizeWord;
    cfg_ssize     = ttr_pkg::SizeWord;
    cfg_length    = ttr_pkg::MaxLength;
    last_trigger  = '0;
    clear_capture();
    mismatches    = 0;
    cycles        = 0;
    items_sent    = 0;
    quiet         = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_trigger_modes();
    test_random();
    quiet = 1'b1;
    test_full_capture();
    wait_drained();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
